[hw/rtl/assert_macros.svh]
// Assertion macros shared by the motion detector RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hw/rtl/fdmd_pkg.sv]
// Types, constants and tables of the frame difference motion detector
package fdmd_pkg;

  localparam int unsigned FRAME_DIM = 240;
  localparam int unsigned PIX_COUNT = FRAME_DIM * FRAME_DIM;
  localparam int unsigned POS_W     = $clog2(PIX_COUNT);
  localparam int unsigned FILL_W    = $clog2(PIX_COUNT + 1);

  localparam int unsigned BOUND_MAX = 3 * PIX_COUNT * 15 / 10;
  localparam int unsigned BOUND_W   = $clog2(BOUND_MAX + 1);
  localparam int unsigned SPAN_W    = BOUND_W;
  localparam int unsigned DIV3_SH   = BOUND_W + 1;
  localparam logic [63:0] DIV3_K    = ((64'd1 << DIV3_SH) + 64'd2) / 64'd3;
  localparam int unsigned DIV3_PW   = 2 * BOUND_W + 1;

  localparam int unsigned PROD_W    = SPAN_W + 4;
  localparam int unsigned DIV100_SH = PROD_W + 7;
  localparam logic [63:0] DIV100_K  = ((64'd1 << DIV100_SH) + 64'd99) / 64'd100;
  localparam int unsigned DIV100_PW = 2 * PROD_W + 7;
  localparam int unsigned CMP_W     = (PROD_W > 16) ? PROD_W : 16;

  localparam int unsigned LIGHT_DEN = PIX_COUNT * 255;
  localparam int unsigned LIGHT_W   = $clog2(LIGHT_DEN);

  localparam int unsigned GRAY_K    = 683;
  localparam int unsigned GRAY_SH   = 11;

  localparam logic [15:0] TALLY_MAX = 16'hFFFF;
  localparam logic [7:0]  MRUN_MAX  = 8'd255;
  localparam logic [6:0]  NRUN_MAX  = 7'd127;
  localparam logic [6:0]  LUMA_TOP  = 7'd127;
  localparam logic [3:0]  SENS_MAX  = 4'd11;

  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int unsigned CNT_W      = $clog2(OUTQ_DEPTH + 1);
  localparam int unsigned DECIDE_LAT = 3;
  localparam int unsigned APB_AW     = 5;

  localparam int unsigned RST_HI   = 3 * PIX_COUNT * 9 / 10;
  localparam int unsigned RST_SPAN = RST_HI / 3;
  localparam int unsigned RST_PROD = RST_SPAN * 3;
  localparam int unsigned RST_MTHR = RST_PROD / 100;

  typedef enum logic [2:0] {
    REG_CHANGE_THR    = 3'd0,
    REG_SENSITIVITY   = 3'd1,
    REG_NIGHT_THR     = 3'd2,
    REG_START_BAND    = 3'd3,
    REG_END_BAND      = 3'd4,
    REG_MOTION_FRAMES = 3'd5,
    REG_NIGHT_FRAMES  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } pixel_t;

  typedef struct packed {
    logic        motion;
    logic        night;
    logic        still;
    logic [6:0]  luma_percent;
    logic [15:0] changed_pixels;
  } result_t;

  typedef struct packed {
    logic [7:0] change_threshold;
    logic [3:0] sensitivity;
    logic [6:0] night_threshold;
    logic [3:0] start_band;
    logic [3:0] end_band;
    logic [7:0] motion_frames;
    logic [5:0] night_frames;
  } cfg_t;

  typedef struct packed {
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
    logic [PROD_W-1:0]  motion_thr;
  } thr_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] tally;
    logic [6:0]  luma;
    logic        luma_big;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } outq_stat_t;

  function automatic logic [BOUND_W-1:0] roi_bound(input logic [3:0] k);
    logic [BOUND_W-1:0] b;
    unique case (k)
      4'd0:    b = BOUND_W'(3 * PIX_COUNT * 0 / 10);
      4'd1:    b = BOUND_W'(3 * PIX_COUNT * 1 / 10);
      4'd2:    b = BOUND_W'(3 * PIX_COUNT * 2 / 10);
      4'd3:    b = BOUND_W'(3 * PIX_COUNT * 3 / 10);
      4'd4:    b = BOUND_W'(3 * PIX_COUNT * 4 / 10);
      4'd5:    b = BOUND_W'(3 * PIX_COUNT * 5 / 10);
      4'd6:    b = BOUND_W'(3 * PIX_COUNT * 6 / 10);
      4'd7:    b = BOUND_W'(3 * PIX_COUNT * 7 / 10);
      4'd8:    b = BOUND_W'(3 * PIX_COUNT * 8 / 10);
      4'd9:    b = BOUND_W'(3 * PIX_COUNT * 9 / 10);
      4'd10:   b = BOUND_W'(3 * PIX_COUNT * 10 / 10);
      4'd11:   b = BOUND_W'(3 * PIX_COUNT * 11 / 10);
      4'd12:   b = BOUND_W'(3 * PIX_COUNT * 12 / 10);
      4'd13:   b = BOUND_W'(3 * PIX_COUNT * 13 / 10);
      4'd14:   b = BOUND_W'(3 * PIX_COUNT * 14 / 10);
      4'd15:   b = BOUND_W'(3 * PIX_COUNT * 15 / 10);
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

[hw/rtl/fdmd_cfg.sv]
// Configuration registers and derived region and motion thresholds
module fdmd_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fdmd_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output fdmd_pkg::cfg_t              cfg_o,
  output fdmd_pkg::thr_t              thr_o
);
  import fdmd_pkg::*;

  cfg_t               cfg_q;
  reg_idx_e           idx;
  logic               wr_en;
  logic [3:0]         k_lo;
  logic [3:0]         factor;
  logic [BOUND_W-1:0] lo_q, hi_q, dist_q;
  logic [SPAN_W-1:0]  span_q, span_d;
  logic [PROD_W-1:0]  prod_q, prod_d, mthr_q, mthr_d;
  logic [DIV3_PW-1:0]   div3_prod;
  logic [DIV100_PW-1:0] div100_prod;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.change_threshold <= 8'd15;
      cfg_q.sensitivity      <= 4'd8;
      cfg_q.night_threshold  <= 7'd20;
      cfg_q.start_band       <= 4'd1;
      cfg_q.end_band         <= 4'd9;
      cfg_q.motion_frames    <= 8'd3;
      cfg_q.night_frames     <= 6'd10;
    end else if (wr_en) begin
      unique case (idx)
        REG_CHANGE_THR:    cfg_q.change_threshold <= pwdata[7:0];
        REG_SENSITIVITY:   cfg_q.sensitivity      <= pwdata[3:0];
        REG_NIGHT_THR:     cfg_q.night_threshold  <= pwdata[6:0];
        REG_START_BAND:    cfg_q.start_band       <= pwdata[3:0];
        REG_END_BAND:      cfg_q.end_band         <= pwdata[3:0];
        REG_MOTION_FRAMES: cfg_q.motion_frames    <= pwdata[7:0];
        REG_NIGHT_FRAMES:  cfg_q.night_frames     <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CHANGE_THR:    prdata = {24'd0, cfg_q.change_threshold};
      REG_SENSITIVITY:   prdata = {28'd0, cfg_q.sensitivity};
      REG_NIGHT_THR:     prdata = {25'd0, cfg_q.night_threshold};
      REG_START_BAND:    prdata = {28'd0, cfg_q.start_band};
      REG_END_BAND:      prdata = {28'd0, cfg_q.end_band};
      REG_MOTION_FRAMES: prdata = {24'd0, cfg_q.motion_frames};
      REG_NIGHT_FRAMES:  prdata = {26'd0, cfg_q.night_frames};
      default:           prdata = 32'd0;
    endcase
  end

  assign k_lo   = (cfg_q.start_band == 4'd0) ? 4'd0 : cfg_q.start_band - 4'd1;
  assign factor = (cfg_q.sensitivity > SENS_MAX) ? 4'd0 : SENS_MAX - cfg_q.sensitivity;

  assign div3_prod   = DIV3_PW'(dist_q) * DIV3_PW'(DIV3_K[BOUND_W-1:0]);
  assign span_d      = div3_prod[DIV3_SH +: SPAN_W];
  assign prod_d      = PROD_W'(span_q) * PROD_W'(factor);
  assign div100_prod = DIV100_PW'(prod_q) * DIV100_PW'(DIV100_K[PROD_W:0]);
  assign mthr_d      = div100_prod[DIV100_SH +: PROD_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q   <= '0;
      hi_q   <= BOUND_W'(RST_HI);
      dist_q <= BOUND_W'(RST_HI);
      span_q <= SPAN_W'(RST_SPAN);
      prod_q <= PROD_W'(RST_PROD);
      mthr_q <= PROD_W'(RST_MTHR);
    end else begin
      lo_q   <= roi_bound(k_lo);
      hi_q   <= roi_bound(cfg_q.end_band);
      dist_q <= (hi_q > lo_q) ? hi_q - lo_q : '0;
      span_q <= span_d;
      prod_q <= prod_d;
      mthr_q <= mthr_d;
    end
  end

  assign cfg_o            = cfg_q;
  assign thr_o.lo         = lo_q;
  assign thr_o.hi         = hi_q;
  assign thr_o.motion_thr = mthr_q;

endmodule

[hw/rtl/fdmd_pix.sv]
// Pixel pipeline: gray conversion, previous frame store and frame accumulators
module fdmd_pix (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  fdmd_pkg::pixel_t     pix_i,
  input  logic [7:0]           change_thr_i,
  input  fdmd_pkg::thr_t       thr_i,
  output fdmd_pkg::frame_t     frame_o
);
  import fdmd_pkg::*;

  logic [7:0]       mem [PIX_COUNT];

  logic [9:0]       gray_sum;
  logic [19:0]      gray_prod;
  logic [7:0]       gray;
  logic [POS_W-1:0] pos_q;
  logic [FILL_W-1:0] fill_q;

  logic             a_valid_q, a_last_q;
  logic [7:0]       a_gray_q;
  logic [POS_W-1:0] a_pos_q;
  logic [7:0]       rd_q;
  logic             fwd_hit_q;
  logic [7:0]       fwd_data_q;

  logic [7:0]         prev, diff;
  logic [BOUND_W-1:0] tri_pos;
  logic               hit;
  logic [14:0]        g100;

  logic               b_valid_q, b_last_q, b_hit_q;
  logic [14:0]        b_g100_q;

  logic [15:0]        tally_q, tally_n;
  logic [LIGHT_W-1:0] rem_q, rem_n;
  logic [LIGHT_W:0]   rem_sum;
  logic               wrap;
  logic [6:0]         luma_q, luma_n;
  logic               big_q, big_n;
  frame_t             frame_q;

  assign gray_sum  = {2'b00, pix_i.red} + {2'b00, pix_i.green} + {2'b00, pix_i.blue};
  assign gray_prod = 20'(gray_sum) * 20'(GRAY_K);
  assign gray      = gray_prod[GRAY_SH +: 8];

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rd_q <= mem[pos_q];
    end
    if (a_valid_q) begin
      mem[a_pos_q] <= a_gray_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      fill_q    <= '0;
      a_valid_q <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      a_valid_q <= accept_i;
      if (accept_i) begin
        fwd_hit_q <= a_valid_q && (a_pos_q == pos_q);
        if (pix_i.last_pixel || pos_q == POS_W'(PIX_COUNT - 1)) begin
          pos_q <= '0;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
      if (a_valid_q && FILL_W'(a_pos_q) == fill_q) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      a_gray_q   <= gray;
      a_pos_q    <= pos_q;
      a_last_q   <= pix_i.last_pixel;
      fwd_data_q <= a_gray_q;
    end
  end

  always_comb begin
    if (fwd_hit_q) begin
      prev = fwd_data_q;
    end else if (FILL_W'(a_pos_q) < fill_q) begin
      prev = rd_q;
    end else begin
      prev = 8'd0;
    end
  end

  assign diff    = (a_gray_q > prev) ? a_gray_q - prev : prev - a_gray_q;
  assign tri_pos = BOUND_W'({a_pos_q, 1'b0}) + BOUND_W'(a_pos_q);
  assign hit     = (diff > change_thr_i) && (tri_pos > thr_i.lo) && (tri_pos < thr_i.hi);
  assign g100    = 15'(a_gray_q) * 15'd100;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      b_last_q <= a_last_q;
      b_hit_q  <= hit;
      b_g100_q <= g100;
    end
  end

  assign tally_n = (b_hit_q && tally_q != TALLY_MAX) ? tally_q + 16'd1 : tally_q;
  assign rem_sum = {1'b0, rem_q} + (LIGHT_W + 1)'(b_g100_q);
  assign wrap    = rem_sum >= (LIGHT_W + 1)'(LIGHT_DEN);
  assign rem_n   = wrap ? LIGHT_W'(rem_sum - (LIGHT_W + 1)'(LIGHT_DEN)) : LIGHT_W'(rem_sum);
  assign luma_n  = luma_q + 7'(wrap);
  assign big_n   = big_q | (wrap && luma_q == LUMA_TOP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q <= '0;
      rem_q   <= '0;
      luma_q  <= '0;
      big_q   <= 1'b0;
      frame_q <= '0;
    end else begin
      frame_q.valid <= b_valid_q && b_last_q;
      if (b_valid_q && b_last_q) begin
        frame_q.tally    <= tally_n;
        frame_q.luma     <= luma_n;
        frame_q.luma_big <= big_n;
      end
      if (b_valid_q) begin
        if (b_last_q) begin
          tally_q <= '0;
          rem_q   <= '0;
          luma_q  <= '0;
          big_q   <= 1'b0;
        end else begin
          tally_q <= tally_n;
          rem_q   <= rem_n;
          luma_q  <= luma_n;
          big_q   <= big_n;
        end
      end
    end
  end

  assign frame_o = frame_q;

endmodule

[hw/rtl/fdmd_dec.sv]
// Frame decision: day and night hysteresis and motion run tracking
module fdmd_dec (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fdmd_pkg::frame_t            frame_i,
  input  fdmd_pkg::cfg_t              cfg_i,
  input  logic [fdmd_pkg::PROD_W-1:0] motion_thr_i,
  output logic                        push_o,
  output fdmd_pkg::result_t           result_o
);
  import fdmd_pkg::*;

  frame_t     dly_q [DECIDE_LAT];
  frame_t     cur;
  logic       night_q, night_n;
  logic [6:0] nrun_q, nrun_n;
  logic [7:0] mrun_q, mrun_n;
  logic       mact_q, status;
  logic       luma_gt, luma_lt, changed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DECIDE_LAT; i++) begin
        dly_q[i] <= '0;
      end
    end else begin
      dly_q[0] <= frame_i;
      for (int i = 1; i < DECIDE_LAT; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  assign cur     = dly_q[DECIDE_LAT-1];
  assign luma_gt = cur.luma_big || (cur.luma > cfg_i.night_threshold);
  assign luma_lt = !cur.luma_big && (cur.luma < cfg_i.night_threshold);
  assign changed = CMP_W'(cur.tally) > CMP_W'(motion_thr_i);

  always_comb begin
    night_n = night_q;
    nrun_n  = nrun_q;
    if (night_q) begin
      if (luma_gt && nrun_q != 7'd0) begin
        nrun_n = nrun_q - 7'd1;
        if (nrun_n == 7'd0) begin
          night_n = 1'b0;
        end
      end
    end else if (luma_lt) begin
      if (nrun_q != NRUN_MAX) begin
        nrun_n = nrun_q + 7'd1;
      end
      if (nrun_n > {1'b0, cfg_i.night_frames}) begin
        night_n = 1'b1;
      end
    end

    status = mact_q;
    mrun_n = mrun_q;
    if (changed) begin
      if (mrun_q != MRUN_MAX) begin
        mrun_n = mrun_q + 8'd1;
      end
      if (!status && mrun_n >= cfg_i.motion_frames) begin
        status = 1'b1;
      end
    end else begin
      mrun_n = 8'd0;
    end
    if (status && mrun_n == 8'd0) begin
      status = 1'b0;
    end
    if (night_n) begin
      status = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      night_q <= 1'b0;
      nrun_q  <= '0;
      mrun_q  <= '0;
      mact_q  <= 1'b0;
    end else if (cur.valid) begin
      night_q <= night_n;
      nrun_q  <= nrun_n;
      mrun_q  <= mrun_n;
      mact_q  <= status;
    end
  end

  assign push_o                  = cur.valid;
  assign result_o.motion         = status;
  assign result_o.night          = night_n;
  assign result_o.still          = !changed;
  assign result_o.luma_percent   = cur.luma;
  assign result_o.changed_pixels = cur.tally;

endmodule

[hw/rtl/fdmd_outq.sv]
// Result queue between the decision stage and the output channel
module fdmd_outq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  fdmd_pkg::result_t    data_i,
  input  logic                 pop_i,
  output logic                 valid_o,
  output fdmd_pkg::result_t    data_o,
  output fdmd_pkg::outq_stat_t stat_o
);
  import fdmd_pkg::*;

  result_t            entry_q [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   level_q;
  logic               do_push, do_pop;

  assign do_pop  = pop_i && (level_q != '0);
  assign do_push = push_i && (level_q != CNT_W'(OUTQ_DEPTH));

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        level_q <= level_q + 1'b1;
      end else if (do_pop && !do_push) begin
        level_q <= level_q - 1'b1;
      end
    end
  end

  assign valid_o      = (level_q != '0);
  assign data_o       = entry_q[rd_ptr_q];
  assign stat_o.full  = (level_q == CNT_W'(OUTQ_DEPTH));
  assign stat_o.empty = (level_q == '0);

endmodule

[hw/rtl/frame_diff_motion_detector.sv]
// Top level of the frame difference motion detector
//
//   channel  direction  handshake                payload
//   in       sink       in_valid_i/in_stall_o    pixel_t (red, green, blue, last_pixel)
//   out      source     out_valid_o/out_stall_i  result_t (one per frame)
//   apb      slave      psel/penable/pready      7 registers at byte address 4*i
//
// One pixel is accepted per cycle unless stalled; the frame store is one synchronous RAM port pair.
// A result passes pixel stages A and B, the frame register and the decision delay line, then enters the output queue.
// Reset takes effect at once: a fill count stands in for clearing the frame store.
// The input stalls only while four frame results are in flight or queued.
`include "assert_macros.svh"
module frame_diff_motion_detector (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  fdmd_pkg::pixel_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output fdmd_pkg::result_t           out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fdmd_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fdmd_pkg::*;

  cfg_t             cfg;
  thr_t             thr;
  frame_t           frame;
  result_t          result;
  outq_stat_t       q_stat;
  logic             accept, pop, push;
  logic [CNT_W-1:0] cnt_q;

  assign accept     = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;
  assign in_stall_o = (cnt_q == CNT_W'(OUTQ_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      if ((accept && in_data_i.last_pixel) && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !(accept && in_data_i.last_pixel)) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  fdmd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .thr_o   (thr)
  );

  fdmd_pix u_pix (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .pix_i        (in_data_i),
    .change_thr_i (cfg.change_threshold),
    .thr_i        (thr),
    .frame_o      (frame)
  );

  fdmd_dec u_dec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_i      (frame),
    .cfg_i        (cfg),
    .motion_thr_i (thr.motion_thr),
    .push_o       (push),
    .result_o     (result)
  );

  fdmd_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (result),
    .pop_i   (pop),
    .valid_o (out_valid_o),
    .data_o  (out_data_o),
    .stat_o  (q_stat)
  );

  `ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(OUTQ_DEPTH), "pending result count overflow")
  `ASSERT_IMPL(a_push_room, push, !q_stat.full, "frame result pushed into a full queue")
  `ASSERT_IMPL(a_out_pending, out_valid_o, cnt_q != '0, "output valid without pending result")

endmodule

[bench/tb_frame_diff_motion_detector.sv]
// Self-checking testbench for the frame difference motion detector
`timescale 1ns / 1ps

module tb_frame_diff_motion_detector;
  import fdmd_pkg::*;

  class motion_tracker;
    byte unsigned prev_gray [PIX_COUNT];
    int unsigned  position;
    longint       light_sum;
    int unsigned  tally;
    int unsigned  motion_run;
    int unsigned  night_run;
    bit           night_flag;
    bit           motion_active;
    cfg_t         cfg;
    result_t      pending_decisions[$];
    int           fails;

    function new();
      cfg.change_threshold = 8'd15;
      cfg.sensitivity      = 4'd8;
      cfg.night_threshold  = 7'd20;
      cfg.start_band       = 4'd1;
      cfg.end_band         = 4'd9;
      cfg.motion_frames    = 8'd3;
      cfg.night_frames     = 6'd10;
      position      = 0;
      light_sum     = 0;
      tally         = 0;
      motion_run    = 0;
      night_run     = 0;
      night_flag    = 1'b0;
      motion_active = 1'b0;
      fails         = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] value);
      case (idx)
        REG_CHANGE_THR:    cfg.change_threshold = value[7:0];
        REG_SENSITIVITY:   cfg.sensitivity      = value[3:0];
        REG_NIGHT_THR:     cfg.night_threshold  = value[6:0];
        REG_START_BAND:    cfg.start_band       = value[3:0];
        REG_END_BAND:      cfg.end_band         = value[3:0];
        REG_MOTION_FRAMES: cfg.motion_frames    = value[7:0];
        REG_NIGHT_FRAMES:  cfg.night_frames     = value[5:0];
        default: ;
      endcase
    endfunction

    function void take_pixel(pixel_t px);
      int unsigned gray;
      int unsigned prev;
      int unsigned diff;
      int unsigned first;
      int unsigned sens;
      longint      lo;
      longint      hi;
      longint      pos3;
      longint      span;
      longint      thr;
      longint      luma;
      bit          changed;
      bit          status;
      result_t     res;
      gray = (32'(px.red) + 32'(px.green) + 32'(px.blue)) / 3;
      prev = prev_gray[position];
      diff = (gray > prev) ? gray - prev : prev - gray;
      light_sum += gray;
      first = (cfg.start_band == 4'd0) ? 1 : cfg.start_band;
      lo   = 3 * longint'(PIX_COUNT) * longint'(first - 1) / 10;
      hi   = 3 * longint'(PIX_COUNT) * longint'(cfg.end_band) / 10;
      pos3 = 3 * longint'(position);
      if (diff > cfg.change_threshold && pos3 > lo && pos3 < hi && tally < TALLY_MAX)
        tally++;
      prev_gray[position] = gray[7:0];
      position = (position + 1 >= PIX_COUNT) ? 0 : position + 1;
      if (!px.last_pixel) return;

      luma = light_sum * 100 / (longint'(PIX_COUNT) * 255);
      if (night_flag) begin
        if (luma > cfg.night_threshold && night_run > 0) begin
          night_run--;
          if (night_run == 0) night_flag = 1'b0;
        end
      end else if (luma < cfg.night_threshold) begin
        if (night_run < NRUN_MAX) night_run++;
        if (night_run > cfg.night_frames) night_flag = 1'b1;
      end

      span    = (hi > lo) ? (hi - lo) / 3 : 0;
      sens    = (cfg.sensitivity > SENS_MAX) ? SENS_MAX : cfg.sensitivity;
      thr     = span * longint'(SENS_MAX - sens) / 100;
      changed = longint'(tally) > thr;

      status = motion_active;
      if (changed) begin
        if (motion_run < MRUN_MAX) motion_run++;
        if (!status && motion_run >= cfg.motion_frames) status = 1'b1;
      end else begin
        motion_run = 0;
      end
      if (status && motion_run == 0) status = 1'b0;
      if (night_flag) status = 1'b0;
      motion_active = status;

      res.motion         = status;
      res.night          = night_flag;
      res.still          = !changed;
      res.luma_percent   = luma[6:0];
      res.changed_pixels = tally[15:0];
      pending_decisions.push_back(res);

      position  = 0;
      light_sum = 0;
      tally     = 0;
    endfunction

    function void compare_field(string name, longint want, longint seen);
      if (want != seen) begin
        $display("%0t %s: expected %0d, got %0d", $time, name, want, seen);
        fails++;
      end
    endfunction

    function void match_decision(result_t got);
      result_t want;
      if (pending_decisions.size() == 0) begin
        $display("%0t unexpected result: expected none, got %p", $time, got);
        fails++;
        return;
      end
      want = pending_decisions.pop_front();
      compare_field("motion", want.motion, got.motion);
      compare_field("night", want.night, got.night);
      compare_field("still", want.still, got.still);
      compare_field("luma_percent", want.luma_percent, got.luma_percent);
      compare_field("changed_pixels", want.changed_pixels, got.changed_pixels);
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  pixel_t            in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  result_t           out_data_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  bit                gaps_on = 1'b1;
  int unsigned       sent = 0;

  motion_tracker tracker = new();

  frame_diff_motion_detector dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i = gaps_on && ($urandom_range(0, 99) < 22);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) tracker.take_pixel(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) tracker.match_decision(out_data_o);
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic pixel_t rgb_item(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                      logic last);
    pixel_t px;
    px.red        = r;
    px.green      = g;
    px.blue       = b;
    px.last_pixel = last;
    return px;
  endfunction

  function automatic pixel_t noise_item(logic last);
    return rgb_item(8'($urandom), 8'($urandom), 8'($urandom), last);
  endfunction

  // gray of the next position flipped around mid-scale, so it always differs
  function automatic pixel_t inverted_item(logic last);
    logic [7:0] v;
    v = 8'd255 - 8'(tracker.prev_gray[tracker.position]);
    return rgb_item(v, v, v, last);
  endfunction

  function automatic cfg_t pick_settings();
    cfg_t c;
    int unsigned k;
    k = $urandom_range(0, 99);
    c.change_threshold = (k < 15) ? 8'd0 : (k < 25) ? 8'd255 : 8'($urandom_range(0, 40));
    k = $urandom_range(0, 99);
    c.sensitivity = (k < 45) ? 4'($urandom_range(11, 15)) :
                    (k < 75) ? 4'($urandom_range(9, 10)) : 4'($urandom_range(0, 8));
    k = $urandom_range(0, 99);
    c.night_threshold = (k < 40) ? 7'd0 : (k < 50) ? 7'd100 : (k < 55) ? 7'd127 :
                        7'($urandom_range(1, 25));
    k = $urandom_range(0, 99);
    c.start_band = (k < 30) ? 4'd0 : (k < 75) ? 4'd1 : 4'($urandom_range(0, 15));
    k = $urandom_range(0, 99);
    c.end_band = (k < 10) ? 4'd15 : (k < 55) ? 4'($urandom_range(1, 3)) :
                 4'($urandom_range(0, 15));
    k = $urandom_range(0, 99);
    c.motion_frames = (k < 10) ? 8'd255 : (k < 15) ? 8'd0 : 8'($urandom_range(1, 4));
    k = $urandom_range(0, 99);
    c.night_frames = (k < 10) ? 6'd63 : 6'($urandom_range(0, 6));
    return c;
  endfunction

  task automatic drive_pixel(input pixel_t px);
    if (gaps_on && $urandom_range(0, 99) < 22) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
      while ($urandom_range(0, 99) < 22) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  // drop valid, wait for every pending result, then let the pipeline drain
  task automatic settle();
    in_valid_i = 1'b0;
    while (tracker.pending_decisions.size() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.set_reg(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apply_settings(input cfg_t c);
    reg_write(REG_CHANGE_THR, 32'(c.change_threshold));
    reg_write(REG_SENSITIVITY, 32'(c.sensitivity));
    reg_write(REG_NIGHT_THR, 32'(c.night_threshold));
    reg_write(REG_START_BAND, 32'(c.start_band));
    reg_write(REG_END_BAND, 32'(c.end_band));
    reg_write(REG_MOTION_FRAMES, 32'(c.motion_frames));
    reg_write(REG_NIGHT_FRAMES, 32'(c.night_frames));
  endtask

  initial begin
    cfg_t        plan;
    pixel_t      fresh[$];
    pixel_t      replay[$];
    int unsigned frames;
    int unsigned len;
    int unsigned k;
    int unsigned i;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    drive_pixel(rgb_item(8'd255, 8'd255, 8'd255, 1'b0));
    drive_pixel(rgb_item(8'd0, 8'd0, 8'd0, 1'b0));
    drive_pixel(rgb_item(8'd1, 8'd2, 8'd3, 1'b0));
    drive_pixel(rgb_item(8'd255, 8'd254, 8'd253, 1'b1));
    drive_pixel(rgb_item(8'd0, 8'd0, 8'd0, 1'b1));

    settle();
    plan = tracker.cfg;
    plan.change_threshold = 8'd0;
    plan.sensitivity      = 4'd15;
    plan.start_band       = 4'd0;
    plan.end_band         = 4'd15;
    plan.motion_frames    = 8'd1;
    apply_settings(plan);
    for (i = 0; i < 2; i++) begin
      drive_pixel(rgb_item(8'd200, 8'd10, 8'd90, 1'b0));
      drive_pixel(rgb_item(8'd7, 8'd7, 8'd7, 1'b0));
      drive_pixel(rgb_item(8'd128, 8'd128, 8'd129, 1'b1));
    end

    settle();
    plan.change_threshold = 8'd255;
    plan.sensitivity      = 4'd0;
    plan.start_band       = 4'd5;
    plan.end_band         = 4'd3;
    apply_settings(plan);
    drive_pixel(rgb_item(8'd0, 8'd255, 8'd0, 1'b0));
    drive_pixel(rgb_item(8'd255, 8'd0, 8'd255, 1'b1));

    // long run of changed frames to saturate the motion run counter, no idling on either side
    settle();
    plan.change_threshold = 8'd0;
    plan.start_band       = 4'd1;
    plan.end_band         = 4'd10;
    plan.night_threshold  = 7'd0;
    plan.sensitivity      = 4'd11;
    plan.motion_frames    = 8'd255;
    apply_settings(plan);
    gaps_on = 1'b0;
    for (i = 0; i < 262; i++) begin
      drive_pixel(noise_item(1'b0));
      drive_pixel(inverted_item(1'b1));
    end
    gaps_on = 1'b1;

    settle();
    plan.night_threshold = 7'd100;
    plan.night_frames    = 6'd0;
    apply_settings(plan);
    drive_pixel(rgb_item(8'd12, 8'd34, 8'd56, 1'b1));

    frames = 0;
    while (sent < 1500) begin
      if (frames % 8 == 0) begin
        settle();
        apply_settings(pick_settings());
      end
      k = $urandom_range(0, 99);
      if (k < 25 && replay.size() != 0) begin
        fresh = replay;
      end else begin
        fresh.delete();
        if (k < 80) len = $urandom_range(1, 12);
        else if (k < 94) len = $urandom_range(13, 120);
        else len = $urandom_range(600, 800);
        for (i = 0; i < len; i++) begin
          if (len >= 600)
            fresh.push_back(rgb_item(8'($urandom_range(250, 255)), 8'($urandom_range(250, 255)),
                                     8'($urandom_range(250, 255)), i == len - 1));
          else
            fresh.push_back(noise_item(i == len - 1));
        end
      end
      foreach (fresh[j]) drive_pixel(fresh[j]);
      replay = fresh;
      frames++;
    end

    settle();
    if (tracker.fails == 0 && tracker.pending_decisions.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
